// ===== rtl/core/aplr_pkg.sv =====
// Shared types and constants for the ATA PIO LBA28 read sequencer.
// Holds the phase and burst encodings and the burst descriptor struct.
// No dependencies.
package aplr_pkg;

  // Sequencing constants.
  localparam int WORDS_PER_SECTOR = 256;
  localparam int GRACE_POLLS      = 4;
  localparam int DELAY_READS      = 4;

  localparam logic [7:0] LAST_WORD_IDX = 8'(WORDS_PER_SECTOR - 1);
  localparam logic [2:0] GRACE_LIMIT   = 3'(GRACE_POLLS);
  localparam logic [2:0] DELAY_LIMIT   = 3'(DELAY_READS);

  // Input function codes.
  localparam logic [1:0] FUNC_START  = 2'd0;
  localparam logic [1:0] FUNC_STATUS = 2'd1;
  localparam logic [1:0] FUNC_DATA   = 2'd2;

  // Status register bits.
  localparam logic [7:0] ST_BSY = 8'h80;
  localparam logic [7:0] ST_RDY = 8'h40;
  localparam logic [7:0] ST_DF  = 8'h20;
  localparam logic [7:0] ST_DRQ = 8'h08;
  localparam logic [7:0] ST_ERR = 8'h01;

  // Command and control bytes.
  localparam logic [7:0] CTRL_SRST   = 8'h04;
  localparam logic [7:0] CMD_READ    = 8'h20;
  localparam logic [7:0] SELECT_BASE = 8'hE0;

  // Register offsets: task file 0..7, device control / alternate status 8.
  localparam logic [3:0] REG_DATA     = 4'd0;
  localparam logic [3:0] REG_FEATURES = 4'd1;
  localparam logic [3:0] REG_COUNT    = 4'd2;
  localparam logic [3:0] REG_LBA_LO   = 4'd3;
  localparam logic [3:0] REG_LBA_MID  = 4'd4;
  localparam logic [3:0] REG_LBA_HI   = 4'd5;
  localparam logic [3:0] REG_DEVICE   = 4'd6;
  localparam logic [3:0] REG_COMMAND  = 4'd7;
  localparam logic [3:0] REG_CTRL     = 4'd8;

  typedef enum logic [2:0] {
    KIND_WRITE = 3'd0,
    KIND_RSTAT = 3'd1,
    KIND_RDATA = 3'd2,
    KIND_WORD  = 3'd3,
    KIND_DONE  = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_CHECK = 3'd1,
    PH_RESET = 3'd2,
    PH_POLL  = 3'd3,
    PH_DATA  = 3'd4,
    PH_DELAY = 3'd5
  } phase_t;

  // Pattern of result beats caused by one input beat.
  typedef enum logic [3:0] {
    BURST_NONE,
    BURST_RSTAT,
    BURST_RDATA,
    BURST_WORD_RSTAT,
    BURST_WORD_RDATA,
    BURST_SRST,
    BURST_CMD_POLL,
    BURST_CMD_DONE,
    BURST_DONE
  } burst_t;

  typedef struct packed {
    burst_t      burst;
    logic [27:0] lba;
    logic        drive;
    logic [7:0]  count;
    logic [15:0] word;
    logic [7:0]  secs;
    logic        fail;
  } burst_desc_t;

endpackage

// ===== rtl/core/ata_pio_lba28_read_sequencer_unit.sv =====
// Top level of the host-side ATA PIO LBA28 read sequencer.
// Instantiates aplr_ctrl and aplr_emit; uses aplr_pkg.
//
// A start beat carries an LBA28 address, a sector count and a drive bit; the
// block then asks for device accesses through its result channel (register
// writes, status reads, data reads) and the host answers each read with a
// status or data beat on the input channel. Data words come back out as word
// beats, and each read ends with a finished beat carrying the number of
// sectors read and a failure flag for ERR or DF. Beats that do not fit the
// current phase are accepted and dropped without any result. Every input beat
// that fits the phase is turned into a burst of one to eight result beats,
// which leave at one per cycle while out_ready is high. Each burst passes
// through the one-entry burst queue and then the current-burst register
// before its first beat is offered. The input side stays ready while the
// burst queue is empty, no burst is current or the current burst is handing
// over its last beat, so single-result beats such as status polls stream at
// one per cycle while out_ready is high and a longer burst holds the input
// back. The current-burst register sets the rate, one beat per cycle.
// Polling has no timeout and no host buffer size check is made.
module ata_pio_lba28_read_sequencer_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_func,
  input  logic [27:0] in_lba,
  input  logic [7:0]  in_sector_count,
  input  logic        in_drive,
  input  logic [7:0]  in_status_byte,
  input  logic [15:0] in_data_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_kind,
  output logic [3:0]  out_reg_addr,
  output logic [7:0]  out_write_value,
  output logic [15:0] out_host_word,
  output logic [7:0]  out_sectors_read,
  output logic        out_failed,
  output logic        out_last
);
  import aplr_pkg::*;

  logic        in_accept;
  logic        desc_valid;
  logic        desc_ready;
  burst_desc_t desc;

  // The input side is open whenever the descriptor queue can take a burst.
  assign in_ready  = desc_ready;
  assign in_accept = in_valid && in_ready;

  aplr_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (in_accept),
    .func         (in_func),
    .lba          (in_lba),
    .sector_count (in_sector_count),
    .drive        (in_drive),
    .status_byte  (in_status_byte),
    .data_word    (in_data_word),
    .desc_valid   (desc_valid),
    .desc         (desc)
  );

  aplr_emit u_emit (
    .clk              (clk),
    .rst_n            (rst_n),
    .desc_valid       (desc_valid),
    .desc             (desc),
    .desc_ready       (desc_ready),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_reg_addr     (out_reg_addr),
    .out_write_value  (out_write_value),
    .out_host_word    (out_host_word),
    .out_sectors_read (out_sectors_read),
    .out_failed       (out_failed),
    .out_last         (out_last)
  );

  // A burst descriptor only ever comes from an accepted input beat.
  a_desc_from_accept: assert property (@(posedge clk) disable iff (!rst_n)
    desc_valid |-> in_accept)
    else $error("burst descriptor without an accepted input beat");

  // The input side only closes when a burst is queued behind a live one.
  a_stall_needs_output: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled while no result beat is pending");

  // A finished beat always closes its burst.
  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == KIND_DONE) |-> out_last)
    else $error("finished beat not marked last");

  // A word to the host is always followed by a further request.
  a_word_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == KIND_WORD) |-> !out_last)
    else $error("host word beat marked last");

endmodule

// ===== rtl/core/aplr_ctrl.sv =====
// Sequencer state and per-beat step logic for the ATA PIO read sequencer.
// Turns each accepted input beat into a burst descriptor; uses aplr_pkg.
module aplr_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic [1:0]          func,
  input  logic [27:0]         lba,
  input  logic [7:0]          sector_count,
  input  logic                drive,
  input  logic [7:0]          status_byte,
  input  logic [15:0]         data_word,
  output logic                desc_valid,
  output aplr_pkg::burst_desc_t desc
);
  import aplr_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [27:0] lba_r, lba_nxt;
  logic        drive_r, drive_nxt;
  logic [7:0]  count_r, count_nxt;
  logic [7:0]  left_r, left_nxt;
  logic [7:0]  done_r, done_nxt;
  logic [7:0]  word_idx_r, word_idx_nxt;
  logic [2:0]  delay_idx_r, delay_idx_nxt;
  logic [2:0]  poll_idx_r, poll_idx_nxt;
  logic        grace_r, grace_nxt;

  logic        do_issue;
  logic        grace_now;
  logic        stop;
  logic [2:0]  delay_inc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      lba_r       <= '0;
      drive_r     <= 1'b0;
      count_r     <= '0;
      left_r      <= '0;
      done_r      <= '0;
      word_idx_r  <= '0;
      delay_idx_r <= '0;
      poll_idx_r  <= '0;
      grace_r     <= 1'b1;
    end else if (accept) begin
      phase_r     <= phase_nxt;
      lba_r       <= lba_nxt;
      drive_r     <= drive_nxt;
      count_r     <= count_nxt;
      left_r      <= left_nxt;
      done_r      <= done_nxt;
      word_idx_r  <= word_idx_nxt;
      delay_idx_r <= delay_idx_nxt;
      poll_idx_r  <= poll_idx_nxt;
      grace_r     <= grace_nxt;
    end
  end

  always_comb begin
    phase_nxt     = phase_r;
    lba_nxt       = lba_r;
    drive_nxt     = drive_r;
    count_nxt     = count_r;
    left_nxt      = left_r;
    done_nxt      = done_r;
    word_idx_nxt  = word_idx_r;
    delay_idx_nxt = delay_idx_r;
    poll_idx_nxt  = poll_idx_r;
    grace_nxt     = grace_r;
    do_issue      = 1'b0;
    grace_now     = grace_r;
    stop          = 1'b0;
    delay_inc     = delay_idx_r + 3'd1;

    desc.burst = BURST_NONE;
    desc.lba   = lba_r;
    desc.drive = drive_r;
    desc.count = count_r;
    desc.word  = data_word;
    desc.secs  = done_r;
    desc.fail  = 1'b0;

    unique case (phase_r)
      PH_IDLE: begin
        if (func == FUNC_START) begin
          lba_nxt       = lba;
          count_nxt     = sector_count;
          drive_nxt     = drive;
          left_nxt      = sector_count;
          done_nxt      = '0;
          word_idx_nxt  = '0;
          delay_idx_nxt = '0;
          poll_idx_nxt  = '0;
          grace_nxt     = 1'b1;
          desc.burst    = BURST_RSTAT;
          phase_nxt     = PH_CHECK;
        end
      end
      PH_DATA: begin
        if (func == FUNC_DATA) begin
          if (word_idx_r == LAST_WORD_IDX) begin
            done_nxt      = done_r + 8'd1;
            delay_idx_nxt = '0;
            desc.burst    = BURST_WORD_RSTAT;
            phase_nxt     = PH_DELAY;
          end else begin
            word_idx_nxt = word_idx_r + 8'd1;
            desc.burst   = BURST_WORD_RDATA;
          end
        end
      end
      PH_CHECK: begin
        if (func == FUNC_STATUS) begin
          if ((status_byte & (ST_BSY | ST_DRQ)) != 8'h00) begin
            delay_idx_nxt = '0;
            desc.burst    = BURST_SRST;
            phase_nxt     = PH_RESET;
          end else begin
            do_issue = 1'b1;
          end
        end
      end
      PH_RESET: begin
        if (func == FUNC_STATUS) begin
          if (delay_idx_r < DELAY_LIMIT) begin
            delay_idx_nxt = delay_inc;
            desc.burst    = BURST_RSTAT;
          end else if ((status_byte & ST_BSY) == 8'h00 &&
                       (status_byte & ST_RDY) != 8'h00) begin
            do_issue = 1'b1;
          end else begin
            desc.burst = BURST_RSTAT;
          end
        end
      end
      PH_POLL: begin
        if (func == FUNC_STATUS) begin
          // The grace window closes once the poll count has saturated.
          if (grace_r && poll_idx_r >= GRACE_LIMIT) begin
            grace_now = 1'b0;
          end
          grace_nxt = grace_now;
          if (poll_idx_r < GRACE_LIMIT) begin
            poll_idx_nxt = poll_idx_r + 3'd1;
          end
          stop = ((status_byte & ST_BSY) == 8'h00) &&
                 (((status_byte & ST_DRQ) != 8'h00) ||
                  (!grace_now && (status_byte & (ST_ERR | ST_DF)) != 8'h00));
          if (!stop) begin
            desc.burst = BURST_RSTAT;
          end else if ((status_byte & (ST_ERR | ST_DF)) != 8'h00) begin
            desc.burst = BURST_DONE;
            desc.fail  = 1'b1;
            phase_nxt  = PH_IDLE;
          end else begin
            grace_nxt    = 1'b0;
            left_nxt     = left_r - 8'd1;
            word_idx_nxt = '0;
            desc.burst   = BURST_RDATA;
            phase_nxt    = PH_DATA;
          end
        end
      end
      PH_DELAY: begin
        if (func == FUNC_STATUS) begin
          delay_idx_nxt = delay_inc;
          if (delay_inc < DELAY_LIMIT) begin
            desc.burst = BURST_RSTAT;
          end else if (left_r != 8'd0) begin
            poll_idx_nxt = '0;
            desc.burst   = BURST_RSTAT;
            phase_nxt    = PH_POLL;
          end else begin
            desc.burst = BURST_DONE;
            phase_nxt  = PH_IDLE;
          end
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase

    // Task-file writes and READ command, then either the first poll or an
    // immediate finish when the sector count is zero.
    if (do_issue) begin
      if (left_r == 8'd0) begin
        desc.burst = BURST_CMD_DONE;
        phase_nxt  = PH_IDLE;
      end else begin
        poll_idx_nxt = '0;
        desc.burst   = BURST_CMD_POLL;
        phase_nxt    = PH_POLL;
      end
    end

    desc_valid = accept && (desc.burst != BURST_NONE);
  end

endmodule

// ===== rtl/core/aplr_emit.sv =====
// Result emitter for the ATA PIO read sequencer (uses aplr_pkg): a one-entry
// descriptor queue feeding a burst walker: one result beat per cycle unless stalled.
module aplr_emit (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  desc_valid,
  input  aplr_pkg::burst_desc_t desc,
  output logic                  desc_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [2:0]            out_kind,
  output logic [3:0]            out_reg_addr,
  output logic [7:0]            out_write_value,
  output logic [15:0]           out_host_word,
  output logic [7:0]            out_sectors_read,
  output logic                  out_failed,
  output logic                  out_last
);
  import aplr_pkg::*;

  logic        pend_valid_r, pend_valid_nxt;
  burst_desc_t pend_r, pend_nxt;
  logic        cur_valid_r, cur_valid_nxt;
  burst_desc_t cur_r, cur_nxt;
  logic [2:0]  idx_r, idx_nxt;

  logic        take;
  logic        take_last;
  logic        cur_free;
  kind_t       kind;

  assign take      = cur_valid_r && out_ready;
  assign take_last = take && out_last;
  assign cur_free  = !cur_valid_r || take_last;
  assign desc_ready = !pend_valid_r || cur_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      cur_valid_r  <= 1'b0;
      idx_r        <= '0;
    end else begin
      pend_valid_r <= pend_valid_nxt;
      cur_valid_r  <= cur_valid_nxt;
      idx_r        <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_r <= pend_nxt;
    cur_r  <= cur_nxt;
  end

  always_comb begin
    pend_valid_nxt = pend_valid_r;
    pend_nxt       = pend_r;
    cur_valid_nxt  = cur_valid_r;
    cur_nxt        = cur_r;
    idx_nxt        = idx_r;

    if (take && !out_last) begin
      idx_nxt = idx_r + 3'd1;
    end else if (take_last) begin
      cur_valid_nxt = 1'b0;
    end

    if (cur_free && pend_valid_r) begin
      cur_nxt        = pend_r;
      cur_valid_nxt  = 1'b1;
      idx_nxt        = '0;
      pend_valid_nxt = 1'b0;
    end

    if (desc_valid && desc_ready) begin
      pend_nxt       = desc;
      pend_valid_nxt = 1'b1;
    end
  end

  // Beat decode from the current descriptor and position within the burst.
  always_comb begin
    kind             = KIND_WRITE;
    out_reg_addr     = REG_DATA;
    out_write_value  = 8'h00;
    out_host_word    = 16'h0000;
    out_sectors_read = 8'h00;
    out_failed       = 1'b0;
    out_last         = 1'b0;

    unique case (cur_r.burst)
      BURST_RSTAT: begin
        kind         = KIND_RSTAT;
        out_reg_addr = REG_CTRL;
        out_last     = 1'b1;
      end
      BURST_RDATA: begin
        kind     = KIND_RDATA;
        out_last = 1'b1;
      end
      BURST_WORD_RSTAT, BURST_WORD_RDATA: begin
        if (idx_r == 3'd0) begin
          kind          = KIND_WORD;
          out_host_word = cur_r.word;
        end else begin
          out_last = 1'b1;
          if (cur_r.burst == BURST_WORD_RSTAT) begin
            kind         = KIND_RSTAT;
            out_reg_addr = REG_CTRL;
          end else begin
            kind = KIND_RDATA;
          end
        end
      end
      BURST_SRST: begin
        out_reg_addr = REG_CTRL;
        unique case (idx_r)
          3'd0:    out_write_value = CTRL_SRST;
          3'd1:    out_write_value = 8'h00;
          default: begin
            kind     = KIND_RSTAT;
            out_last = 1'b1;
          end
        endcase
      end
      BURST_CMD_POLL, BURST_CMD_DONE: begin
        unique case (idx_r)
          3'd0: begin
            out_reg_addr    = REG_DEVICE;
            out_write_value = SELECT_BASE | {3'b000, cur_r.drive, cur_r.lba[27:24]};
          end
          3'd1: out_reg_addr = REG_FEATURES;
          3'd2: begin
            out_reg_addr    = REG_COUNT;
            out_write_value = cur_r.count;
          end
          3'd3: begin
            out_reg_addr    = REG_LBA_LO;
            out_write_value = cur_r.lba[7:0];
          end
          3'd4: begin
            out_reg_addr    = REG_LBA_MID;
            out_write_value = cur_r.lba[15:8];
          end
          3'd5: begin
            out_reg_addr    = REG_LBA_HI;
            out_write_value = cur_r.lba[23:16];
          end
          3'd6: begin
            out_reg_addr    = REG_COMMAND;
            out_write_value = CMD_READ;
          end
          default: begin
            out_last = 1'b1;
            if (cur_r.burst == BURST_CMD_POLL) begin
              kind         = KIND_RSTAT;
              out_reg_addr = REG_CTRL;
            end else begin
              kind             = KIND_DONE;
              out_sectors_read = cur_r.secs;
            end
          end
        endcase
      end
      BURST_DONE: begin
        kind             = KIND_DONE;
        out_sectors_read = cur_r.secs;
        out_failed       = cur_r.fail;
        out_last         = 1'b1;
      end
      default: begin
        out_last = 1'b1;
      end
    endcase
  end

  assign out_valid = cur_valid_r;
  assign out_kind  = kind;

endmodule
